### hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared entry, command and status types for the queue cells and top level.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 32;
    localparam int COUNT_W = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cmd;

endpackage
`default_nettype wire

### hdl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; shifts right on insert, left on removal.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  wire logic   i_clk,
    input  wire t_cmd   i_cmd,
    input  wire logic   i_occupied,
    input  wire logic   i_left_ins,
    input  wire t_entry i_left,
    input  wire t_entry i_right,
    output logic        o_ins,
    output t_entry      o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // The new item goes behind every held entry of lower or equal priority.
    assign o_ins   = !i_occupied || ($signed(r_entry.prio) > $signed(i_cmd.item.prio));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.deq) begin
            n_entry = i_right;
        end else if (i_cmd.enq && o_ins) begin
            n_entry = i_left_ins ? i_left : i_cmd.item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

### hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of data and priority pairs kept in a sorted chain of cells.
// ----------------------------------------------------------------------------
// Each input item on the s_axis channel is an enqueue or a dequeue, selected
// by s_axis_tuser. Every item yields exactly one result item on m_axis with a
// status, the removed entry on a successful dequeue and the count afterwards.
// The smallest priority leaves first; equal priorities leave in arrival order.
// All cells compare the new priority in parallel and shift together, so an
// item is done in the cycle it is accepted and its result appears in the
// output register in the next cycle. One item is accepted per cycle while
// the receiver takes results; the output register is the only storage between
// the two sides, so s_axis_tready follows m_axis_tready while a result waits.
// Reset empties the queue and drops any pending result. When the receiver
// stalls, the result holds and no further item is accepted.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // item_data, item_priority
    input  wire logic [0:0]  s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // out_data, out_priority, count, zero fill
    output logic [1:0]       m_axis_tuser   // status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    t_entry           r_out_entry;
    t_entry           n_out_entry;
    logic [4:0]       r_out_count;
    logic [CNT_W+4:0] count_ext;

    logic   accept;
    logic   is_full;
    logic   is_empty;
    t_cmd   cmd;
    t_entry entries [CAPACITY];
    logic   ins     [CAPACITY];
    logic   occupied[CAPACITY];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_full       = (r_count == CNT_W'(CAPACITY));
    assign is_empty      = (r_count == '0);

    assign cmd.item.data = s_axis_tdata[31:0];
    assign cmd.item.prio = s_axis_tdata[63:32];
    assign cmd.enq       = accept && (s_axis_tuser[0] == OP_ENQ) && !is_full;
    assign cmd.deq       = accept && (s_axis_tuser[0] == OP_DEQ) && !is_empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign occupied[g] = (CNT_W'(g) < r_count);
        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_occupied (occupied[g]),
            .i_left_ins ((g == 0) ? 1'b0 : ins[(g == 0) ? 0 : g - 1]),
            .i_left     (entries[(g == 0) ? 0 : g - 1]),
            .i_right    (entries[(g == CAPACITY - 1) ? g : g + 1]),
            .o_ins      (ins[g]),
            .o_entry    (entries[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_out_entry = '0;
        if (s_axis_tuser[0] == OP_ENQ) begin
            if (is_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (is_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count     = r_count - 1'b1;
                n_out_entry = entries[0];
            end
        end
    end

    assign count_ext = {5'b0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_out_entry <= n_out_entry;
            r_out_count <= count_ext[4:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {3'b0, r_out_count, r_out_entry.prio, r_out_entry.data};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Entry count above capacity.");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.enq |=> r_count == $past(r_count) + 1'b1)
        else $error("Insert did not advance the count.");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.deq |=> r_count == $past(r_count) - 1'b1)
        else $error("Removal did not lower the count.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("Accepted item produced no result.");

endmodule
`default_nettype wire
